/* hdl/siv_pkg.sv */
// ----------------------------------------------------------------------------
// siv_pkg
// Types and constants shared by the swerve inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package siv_pkg;

  localparam int CW      = 30;
  localparam int ZW      = 34;
  localparam int MW      = 27;
  localparam int NW      = MW + 16;
  localparam int QW      = 16;
  localparam int PW      = CW + 17;
  localparam int TAB_LEN = 24;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] zr_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic        [MW-1:0] mag_t;
  typedef logic        [NW-1:0] num_t;

  localparam logic signed [16:0] INV_GAIN = 17'sd39797;
  localparam zr_t  QUARTER = 34'sd1073741824;
  localparam zr_t  HALF    = 34'sd2147483648;
  localparam mag_t ONE_INT = 27'd4194304;

  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670675,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic stop;
    cw_t  t;
  } rot_side_t;

  typedef struct packed {
    logic                 stop;
    logic                 sel;
    logic [3:0][15:0]     ang;
    logic [3:0][15:0]     small_sp;
  } div_side_t;

endpackage

/* hdl/siv_cmd_if.sv */
// ----------------------------------------------------------------------------
// siv_cmd_if
// Command channel: field-frame drive command and robot heading.
// ----------------------------------------------------------------------------
interface siv_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] fwd_cmd;
  logic signed [15:0] strafe_cmd;
  logic signed [15:0] turn_cmd;
  logic        [15:0] heading;

  modport source(output valid, fwd_cmd, strafe_cmd, turn_cmd, heading, input ready);
  modport sink(input valid, fwd_cmd, strafe_cmd, turn_cmd, heading, output ready);
endinterface

/* hdl/siv_res_if.sv */
// ----------------------------------------------------------------------------
// siv_res_if
// Result channel: stop flag and per-wheel steering angle and speed.
// ----------------------------------------------------------------------------
interface siv_res_if;
  logic               valid;
  logic               ready;
  logic               stop;
  logic signed [15:0] fl_angle;
  logic        [15:0] fl_speed;
  logic signed [15:0] fr_angle;
  logic        [15:0] fr_speed;
  logic signed [15:0] bl_angle;
  logic        [15:0] bl_speed;
  logic signed [15:0] br_angle;
  logic        [15:0] br_speed;

  modport source(output valid, stop, fl_angle, fl_speed, fr_angle, fr_speed,
                 bl_angle, bl_speed, br_angle, br_speed, input ready);
  modport sink(input valid, stop, fl_angle, fl_speed, fr_angle, fr_speed,
               bl_angle, bl_speed, br_angle, br_speed, output ready);
endinterface

/* hdl/siv_rot.sv */
// ----------------------------------------------------------------------------
// siv_rot
// Pipelined CORDIC rotator, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module siv_rot #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  siv_pkg::cw_t       x_in,
  input  siv_pkg::cw_t       y_in,
  input  siv_pkg::zr_t       z_in,
  input  siv_pkg::rot_side_t side_in,
  output logic               out_valid,
  output siv_pkg::cw_t       x_out,
  output siv_pkg::cw_t       y_out,
  output siv_pkg::rot_side_t side_out
);
  import siv_pkg::*;

  logic [STAGES:0] v;
  cw_t       x  [STAGES+1];
  cw_t       y  [STAGES+1];
  zr_t       z  [STAGES+1];
  rot_side_t sd [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= x_in;
      y[0]  <= y_in;
      z[0]  <= z_in;
      sd[0] <= side_in;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    cw_t sx, sy;
    assign sx = x[i] >>> i;
    assign sy = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - sy;
          y[i+1] <= y[i] + sx;
          z[i+1] <= z[i] - ZW'(ATAN_TAB[i]);
        end else begin
          x[i+1] <= x[i] + sy;
          y[i+1] <= y[i] - sx;
          z[i+1] <= z[i] + ZW'(ATAN_TAB[i]);
        end
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = v[STAGES];
  assign x_out     = x[STAGES];
  assign y_out     = y[STAGES];
  assign side_out  = sd[STAGES];
endmodule

/* hdl/siv_vec.sv */
// ----------------------------------------------------------------------------
// siv_vec
// Four-lane pipelined CORDIC in vectoring mode: magnitude and angle per wheel.
// ----------------------------------------------------------------------------
module siv_vec #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               stop_in,
  input  siv_pkg::cw_t       x_in [4],
  input  siv_pkg::cw_t       y_in [4],
  output logic               out_valid,
  output logic               stop_out,
  output logic [3:0]         zero_out,
  output siv_pkg::cw_t       x_out [4],
  output logic [31:0]        z_out [4]
);
  import siv_pkg::*;

  logic [STAGES:0] v;
  logic            st [STAGES+1];
  logic [3:0]      zf [STAGES+1];
  cw_t             x  [STAGES+1][4];
  cw_t             y  [STAGES+1][4];
  logic [31:0]     z  [STAGES+1][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= stop_in;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_in
    always_ff @(posedge clk) begin
      if (en) begin
        zf[0][l] <= (x_in[l] == '0) && (y_in[l] == '0);
        if (x_in[l][CW-1]) begin
          x[0][l] <= -x_in[l];
          y[0][l] <= -y_in[l];
          z[0][l] <= 32'h8000_0000;
        end else begin
          x[0][l] <= x_in[l];
          y[0][l] <= y_in[l];
          z[0][l] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= st[i];
        zf[i+1] <= zf[i];
      end
    end
    for (genvar l = 0; l < 4; l++) begin : g_lane
      cw_t sx, sy;
      assign sx = x[i][l] >>> i;
      assign sy = y[i][l] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          if (!y[i][l][CW-1]) begin
            x[i+1][l] <= x[i][l] + sy;
            y[i+1][l] <= y[i][l] - sx;
            z[i+1][l] <= z[i][l] + ATAN_TAB[i];
          end else begin
            x[i+1][l] <= x[i][l] - sy;
            y[i+1][l] <= y[i][l] + sx;
            z[i+1][l] <= z[i][l] - ATAN_TAB[i];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_out
    assign x_out[l] = x[STAGES][l];
    assign z_out[l] = z[STAGES][l];
  end

  assign out_valid = v[STAGES];
  assign stop_out  = st[STAGES];
  assign zero_out  = zf[STAGES];
endmodule

/* hdl/siv_div.sv */
// ----------------------------------------------------------------------------
// siv_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module siv_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  siv_pkg::num_t      num_in [4],
  input  siv_pkg::mag_t      den_in,
  input  siv_pkg::div_side_t side_in,
  output logic               out_valid,
  output logic [15:0]        q_out [4],
  output siv_pkg::div_side_t side_out
);
  import siv_pkg::*;

  logic [QW:0] v;
  num_t        r  [QW+1][4];
  logic [15:0] q  [QW+1][4];
  mag_t        d  [QW+1];
  div_side_t   sd [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0]  <= den_in;
      sd[0] <= side_in;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_in
    always_ff @(posedge clk) begin
      if (en) begin
        r[0][l] <= num_in[l];
        q[0][l] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    always_ff @(posedge clk) begin
      if (en) begin
        d[k+1]  <= d[k];
        sd[k+1] <= sd[k];
      end
    end
    for (genvar l = 0; l < 4; l++) begin : g_lane
      num_t dsh;
      assign dsh = NW'(d[k]) << B;
      always_ff @(posedge clk) begin
        if (en) begin
          if (r[k][l] >= dsh) begin
            r[k+1][l] <= r[k][l] - dsh;
            q[k+1][l] <= q[k][l] | (16'd1 << B);
          end else begin
            r[k+1][l] <= r[k][l];
            q[k+1][l] <= q[k][l];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_out
    assign q_out[l] = q[QW][l];
  end

  assign out_valid = v[QW];
  assign side_out  = sd[QW];
endmodule

/* hdl/swerve_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics
// Four-wheel swerve inverse kinematics: field-frame command to wheel angles
// and normalized speeds.
//
//   channel   dir  handshake        word
//   cmd       in   valid/ready      fwd_cmd, strafe_cmd, turn_cmd, heading
//   res       out  valid/ready      stop, {fl,fr,bl,br}_angle/_speed
//   wr        in   wr_en            wr_index, wr_data
//
// One command per cycle while res is not stalled; each word passes through the
// rotator and vectoring CORDIC stages and the 16-stage divider.
// All stages share one advance enable, so a stall on res freezes the whole
// pipeline and nothing is lost or repeated. Synchronous reset clears valid
// bits and restores both ratio registers.
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  siv_cmd_if.sink     cmd,
  siv_res_if.source   res,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);
  import siv_pkg::*;

  logic [15:0] length_ratio;
  logic [15:0] width_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_ratio <= 16'd46341;
      width_ratio  <= 16'd46341;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LENGTH: length_ratio <= wr_data;
        REG_WIDTH:  width_ratio  <= wr_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !res.valid || res.ready;
  assign cmd.ready = en;

  cw_t       f0, s0, t0, rx, ry;
  zr_t       z0, zs;
  logic [15:0] hneg;
  rot_side_t side0;

  always_comb begin
    f0   = cw_t'($signed({cmd.fwd_cmd, 8'd0}));
    s0   = cw_t'($signed({cmd.strafe_cmd, 8'd0}));
    t0   = cw_t'($signed({cmd.turn_cmd, 8'd0}));
    hneg = 16'd0 - cmd.heading;
    zs   = zr_t'($signed({hneg, 16'd0}));
    z0   = zs;
    rx   = f0;
    ry   = s0;
    if (zs > QUARTER) begin
      z0 = zs - HALF;
      rx = -f0;
      ry = -s0;
    end else if (zs < -QUARTER) begin
      z0 = zs + HALF;
      rx = -f0;
      ry = -s0;
    end
    side0.stop = (cmd.fwd_cmd == '0) && (cmd.strafe_cmd == '0) && (cmd.turn_cmd == '0);
    side0.t    = t0;
  end

  logic      rot_valid;
  cw_t       rot_x, rot_y;
  rot_side_t rot_side;

  siv_rot #(.STAGES(CORDIC_STAGES)) u_rot (
    .clk(clk), .rst(rst), .en(en), .in_valid(cmd.valid),
    .x_in(rx), .y_in(ry), .z_in(z0), .side_in(side0),
    .out_valid(rot_valid), .x_out(rot_x), .y_out(rot_y), .side_out(rot_side)
  );

  logic  v_g, stop_g;
  prod_t px, py;
  cw_t   t_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_g <= 1'b0;
    end else if (en) begin
      v_g <= rot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px     <= rot_x * INV_GAIN;
      py     <= rot_y * INV_GAIN;
      t_g    <= rot_side.t;
      stop_g <= rot_side.stop;
    end
  end

  logic  v_p, stop_p;
  cw_t   f_p, s_p, tn;
  prod_t pl, pw;

  assign tn = -t_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else if (en) begin
      v_p <= v_g;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_p    <= cw_t'(px >>> 16);
      s_p    <= -cw_t'(py >>> 16);
      pl     <= tn * $signed({1'b0, length_ratio});
      pw     <= tn * $signed({1'b0, width_ratio});
      stop_p <= stop_g;
    end
  end

  cw_t tl, tw, ta, tb, tc, td;
  cw_t vx [4];
  cw_t vy [4];

  always_comb begin
    tl    = cw_t'(pl >>> 16);
    tw    = cw_t'(pw >>> 16);
    ta    = s_p - tl;
    tb    = s_p + tl;
    tc    = f_p - tw;
    td    = f_p + tw;
    vy[0] = tb; vx[0] = td;
    vy[1] = tb; vx[1] = tc;
    vy[2] = ta; vx[2] = td;
    vy[3] = ta; vx[3] = tc;
  end

  logic        vec_valid, vec_stop;
  logic [3:0]  vec_zero;
  cw_t         vec_x [4];
  logic [31:0] vec_z [4];

  siv_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_p), .stop_in(stop_p),
    .x_in(vx), .y_in(vy),
    .out_valid(vec_valid), .stop_out(vec_stop), .zero_out(vec_zero),
    .x_out(vec_x), .z_out(vec_z)
  );

  logic        v_m1, stop_m1;
  logic [3:0]  zero_m1;
  prod_t       pm     [4];
  logic [15:0] ang_m1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
    end else if (en) begin
      v_m1 <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stop_m1 <= vec_stop;
      zero_m1 <= vec_zero;
    end
  end

  logic        v_m2, stop_m2;
  mag_t        mag    [4];
  logic [15:0] ang_m2 [4];

  for (genvar l = 0; l < 4; l++) begin : g_mag
    logic [31:0]           zr;
    logic signed [PW-17:0] ms;
    assign zr = vec_z[l] + 32'h0000_8000;
    assign ms = (PW-16)'(pm[l] >>> 16);
    always_ff @(posedge clk) begin
      if (en) begin
        pm[l]     <= vec_x[l] * INV_GAIN;
        ang_m1[l] <= 16'd0 - zr[31:16];
        if (zero_m1[l] || ms[PW-17]) begin
          mag[l] <= '0;
        end else begin
          mag[l] <= MW'(ms);
        end
        ang_m2[l] <= zero_m1[l] ? 16'd0 : ang_m1[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m2 <= 1'b0;
    end else if (en) begin
      v_m2 <= v_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stop_m2 <= stop_m1;
    end
  end

  mag_t      m01, m23, mx;
  num_t      num [4];
  div_side_t dside;

  always_comb begin
    m01        = (mag[1] > mag[0]) ? mag[1] : mag[0];
    m23        = (mag[3] > mag[2]) ? mag[3] : mag[2];
    mx         = (m23 > m01) ? m23 : m01;
    dside.stop = stop_m2;
    dside.sel  = mx > ONE_INT;
    for (int l = 0; l < 4; l++) begin
      num[l]            = (NW'(mag[l]) << 15) + NW'(mx >> 1);
      dside.ang[l]      = ang_m2[l];
      dside.small_sp[l] = 16'(({1'b0, mag[l]} + (MW+1)'(64)) >> 7);
    end
  end

  logic        div_valid;
  logic [15:0] quo [4];
  div_side_t   dout;

  siv_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_m2),
    .num_in(num), .den_in(mx), .side_in(dside),
    .out_valid(div_valid), .q_out(quo), .side_out(dout)
  );

  logic [15:0] sp [4];
  logic [15:0] an [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sp[l] = dout.stop ? 16'd0 : (dout.sel ? quo[l] : dout.small_sp[l]);
      an[l] = dout.stop ? 16'd0 : dout.ang[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.stop     <= dout.stop;
      res.fl_angle <= an[0];
      res.fl_speed <= sp[0];
      res.fr_angle <= an[1];
      res.fr_speed <= sp[1];
      res.bl_angle <= an[2];
      res.bl_speed <= sp[2];
      res.br_angle <= an[3];
      res.br_speed <= sp[3];
    end
  end

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.stop) |-> (res.fl_speed == 16'd0 && res.fr_speed == 16'd0 &&
                                 res.bl_speed == 16'd0 && res.br_speed == 16'd0))
    else $error("stop word carries nonzero speed");

  a_speed_max: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.fl_speed <= 16'd32768 && res.fr_speed <= 16'd32768 &&
                   res.bl_speed <= 16'd32768 && res.br_speed <= 16'd32768))
    else $error("wheel speed above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v_m2 && !en) |=> v_m2)
    else $error("stalled stage dropped its word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");
endmodule
